// ===== hw/rtl/lvpd_pkg.sv =====
// Shared types and constants for the latency-vote preamble deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package lvpd_pkg;

	localparam int LAT_W     = 16;
	localparam int PATTERN_W = 6;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [LAT_W-1:0]     MISS_THRESHOLD_RST   = 16'd200;
	localparam logic [PATTERN_W-1:0] PREAMBLE_PATTERN_RST = 6'b101011;

	// register index, taken from paddr[2]
	typedef enum logic {
		REG_MISS_THRESHOLD   = 1'b0,
		REG_PREAMBLE_PATTERN = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [LAT_W-1:0] access_latency;
		logic             window_end;
	} sample_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_value;
		logic              message_end;
		logic              truncated;
	} result_t;

	// voted bit of the item in the input register
	typedef struct packed {
		logic valid;
		logic value;
	} vote_bit_t;

	// result the item in the input register would produce
	typedef struct packed {
		logic    valid;
		result_t item;
	} frame_out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lvpd_regs.sv =====
// APB-style configuration registers: miss threshold and preamble pattern.
// Depends on lvpd_pkg.
`default_nettype none

module lvpd_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lvpd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lvpd_pkg::DATA_W-1:0]  pwdata,
	output logic      [lvpd_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output logic      [lvpd_pkg::LAT_W-1:0]   miss_threshold,
	output logic      [lvpd_pkg::PATTERN_W-1:0] preamble_pattern
);
	import lvpd_pkg::*;

	logic [LAT_W-1:0]     miss_threshold_q;
	logic [PATTERN_W-1:0] preamble_pattern_q;
	logic                 wr_en;
	reg_idx_t             idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miss_threshold_q   <= MISS_THRESHOLD_RST;
			preamble_pattern_q <= PREAMBLE_PATTERN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_MISS_THRESHOLD:   miss_threshold_q   <= pwdata[LAT_W-1:0];
				REG_PREAMBLE_PATTERN: preamble_pattern_q <= pwdata[PATTERN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MISS_THRESHOLD:   prdata = DATA_W'(miss_threshold_q);
			REG_PREAMBLE_PATTERN: prdata = DATA_W'(preamble_pattern_q);
			default:              prdata = '0;
		endcase
	end

	assign miss_threshold   = miss_threshold_q;
	assign preamble_pattern = preamble_pattern_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lvpd_vote.sv =====
// Window vote: saturating hit/miss counters and the majority bit at window end.
// Depends on lvpd_pkg.
`default_nettype none

module lvpd_vote #(
	parameter int MAX_WINDOW_SAMPLES = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        fire,
	input  wire lvpd_pkg::sample_t           sample_s1,
	input  wire logic [lvpd_pkg::LAT_W-1:0]  miss_threshold,
	output lvpd_pkg::vote_bit_t              vote
);
	import lvpd_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOW_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_SAMPLES);

	logic [CNT_W-1:0] hit_count_q, miss_count_q;
	logic [CNT_W-1:0] hit_next, miss_next;
	logic             is_miss;

	assign is_miss = sample_s1.access_latency > miss_threshold;

	always_comb begin
		hit_next  = hit_count_q;
		miss_next = miss_count_q;
		if (is_miss) begin
			if (miss_count_q < CNT_MAX) miss_next = miss_count_q + 1'b1;
		end else begin
			if (hit_count_q < CNT_MAX) hit_next = hit_count_q + 1'b1;
		end
	end

	// valid is not gated by fire: the result path must not loop back into fire
	assign vote.valid = sample_s1.window_end;
	assign vote.value = miss_next >= hit_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_count_q  <= '0;
			miss_count_q <= '0;
		end else if (fire) begin
			if (sample_s1.window_end) begin
				hit_count_q  <= '0;
				miss_count_q <= '0;
			end else begin
				hit_count_q  <= hit_next;
				miss_count_q <= miss_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lvpd_deframe.sv =====
// Preamble hunt and byte deframing of the voted bit stream.
// Depends on lvpd_pkg.
`default_nettype none

module lvpd_deframe #(
	parameter int MAX_MESSAGE_BYTES = 125,
	parameter int PREAMBLE_BITS     = 6
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            fire,
	input  wire lvpd_pkg::vote_bit_t             vote,
	input  wire logic [lvpd_pkg::PATTERN_W-1:0]  preamble_pattern,
	output lvpd_pkg::frame_out_t                 frame
);
	import lvpd_pkg::*;

	localparam int NB_W = $clog2(MAX_MESSAGE_BYTES + 1);
	localparam logic [NB_W-1:0] NB_MAX = NB_W'(MAX_MESSAGE_BYTES);

	logic                     receiving_q;
	logic [PREAMBLE_BITS-1:0] sync_shift_q;
	logic [BYTE_W-1:0]        byte_shift_q;
	logic [2:0]               bit_position_q;
	logic [NB_W-1:0]          bytes_received_q;

	logic [PREAMBLE_BITS:0]   sync_wide;
	logic [PREAMBLE_BITS-1:0] sync_next, pattern_ext;
	logic [BYTE_W-1:0]        byte_next;
	logic [NB_W-1:0]          bytes_next;
	logic                     sync_match, byte_done, byte_zero, at_limit;

	assign sync_wide   = {sync_shift_q, vote.value};
	assign sync_next   = sync_wide[PREAMBLE_BITS-1:0];
	// zero-extended or trimmed to the preamble length
	assign pattern_ext = PREAMBLE_BITS'(preamble_pattern);
	assign sync_match  = sync_next == pattern_ext;

	assign byte_next  = {byte_shift_q[BYTE_W-2:0], vote.value};
	assign byte_done  = bit_position_q == 3'd7;
	assign byte_zero  = byte_next == '0;
	assign bytes_next = bytes_received_q + 1'b1;
	assign at_limit   = bytes_next >= NB_MAX;

	always_comb begin
		frame.valid                 = vote.valid && receiving_q && byte_done;
		frame.item.byte_value       = byte_next;
		frame.item.message_end      = byte_zero;
		frame.item.truncated        = !byte_zero && at_limit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q      <= 1'b0;
			sync_shift_q     <= '0;
			byte_shift_q     <= '0;
			bit_position_q   <= '0;
			bytes_received_q <= '0;
		end else if (fire && vote.valid) begin
			if (!receiving_q) begin
				sync_shift_q <= sync_next;
				if (sync_match) begin
					receiving_q      <= 1'b1;
					byte_shift_q     <= '0;
					bit_position_q   <= '0;
					bytes_received_q <= '0;
				end
			end else if (!byte_done) begin
				byte_shift_q   <= byte_next;
				bit_position_q <= bit_position_q + 1'b1;
			end else if (byte_zero || at_limit) begin
				// message over: back to hunting
				receiving_q      <= 1'b0;
				sync_shift_q     <= '0;
				byte_shift_q     <= '0;
				bit_position_q   <= '0;
				bytes_received_q <= '0;
			end else begin
				byte_shift_q     <= '0;
				bit_position_q   <= '0;
				bytes_received_q <= bytes_next;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/latency_vote_preamble_deframer.sv =====
// Top level of the latency-vote preamble deframer: input register, vote, deframer,
// result register and configuration port. Depends on lvpd_pkg and the lvpd_* modules.
`default_nettype none

// One latency sample is accepted per cycle unless the input stalls, as said below. An
// accepted item waits in the input register, where the window vote and the deframer
// process it in a single pass; a byte or end marker it causes is then registered in
// the result register, from which it is offered. The result register lets the next
// item be taken while a result waits; only when a waiting result is not taken and the
// item in the input register would produce another does the input stall.
// Configuration writes take effect for items processed after the write.
module latency_vote_preamble_deframer #(
	parameter int MAX_WINDOW_SAMPLES = 256,
	parameter int MAX_MESSAGE_BYTES  = 125,
	parameter int PREAMBLE_BITS      = 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         sample_valid,
	output logic                              sample_ready,
	input  wire lvpd_pkg::sample_t            sample,
	output logic                              result_valid,
	input  wire logic                         result_ready,
	output lvpd_pkg::result_t                 result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [lvpd_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [lvpd_pkg::DATA_W-1:0]  pwdata,
	output logic      [lvpd_pkg::DATA_W-1:0]  prdata,
	output logic                              pready
);
	import lvpd_pkg::*;

	logic                 valid_s1;
	sample_t              sample_s1;
	logic                 advance;
	logic                 result_valid_q;
	result_t              result_q;
	logic [LAT_W-1:0]     miss_threshold;
	logic [PATTERN_W-1:0] preamble_pattern;
	vote_bit_t            vote;
	frame_out_t           frame;

	lvpd_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.miss_threshold   (miss_threshold),
		.preamble_pattern (preamble_pattern)
	);

	lvpd_vote #(
		.MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES)
	) u_vote (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance),
		.sample_s1      (sample_s1),
		.miss_threshold (miss_threshold),
		.vote           (vote)
	);

	lvpd_deframe #(
		.MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
		.PREAMBLE_BITS     (PREAMBLE_BITS)
	) u_deframe (
		.clk              (clk),
		.arst_n           (arst_n),
		.fire             (advance),
		.vote             (vote),
		.preamble_pattern (preamble_pattern),
		.frame            (frame)
	);

	// item leaves the input register unless its result would overrun a held one
	assign advance      = valid_s1 && (!frame.valid || !result_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && frame.valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && frame.valid) begin
			result_q <= frame.item;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire
